// File: design/ulb_pkg.sv
// ----------------------------------------------------------------------------
// ulb_pkg
// Shared types, class codes and the line break rule chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ulb_pkg;

	localparam int POS_BITS = 16;
	localparam int OUT_POS_W = 16;
	localparam int MAX_RES = 4;

	localparam logic [5:0] C_AI = 6'd0;
	localparam logic [5:0] C_AK = 6'd1;
	localparam logic [5:0] C_AL = 6'd2;
	localparam logic [5:0] C_AP = 6'd3;
	localparam logic [5:0] C_AS = 6'd4;
	localparam logic [5:0] C_B2 = 6'd5;
	localparam logic [5:0] C_BA = 6'd6;
	localparam logic [5:0] C_BB = 6'd7;
	localparam logic [5:0] C_BK = 6'd8;
	localparam logic [5:0] C_CB = 6'd9;
	localparam logic [5:0] C_CJ = 6'd10;
	localparam logic [5:0] C_CL = 6'd11;
	localparam logic [5:0] C_CM = 6'd12;
	localparam logic [5:0] C_CP = 6'd13;
	localparam logic [5:0] C_CR = 6'd14;
	localparam logic [5:0] C_EB = 6'd15;
	localparam logic [5:0] C_EM = 6'd16;
	localparam logic [5:0] C_EX = 6'd17;
	localparam logic [5:0] C_GL = 6'd18;
	localparam logic [5:0] C_H2 = 6'd19;
	localparam logic [5:0] C_H3 = 6'd20;
	localparam logic [5:0] C_HH = 6'd21;
	localparam logic [5:0] C_HL = 6'd22;
	localparam logic [5:0] C_HY = 6'd23;
	localparam logic [5:0] C_ID = 6'd24;
	localparam logic [5:0] C_IN = 6'd25;
	localparam logic [5:0] C_IS = 6'd26;
	localparam logic [5:0] C_JL = 6'd27;
	localparam logic [5:0] C_JT = 6'd28;
	localparam logic [5:0] C_JV = 6'd29;
	localparam logic [5:0] C_LF = 6'd30;
	localparam logic [5:0] C_NL = 6'd31;
	localparam logic [5:0] C_NS = 6'd32;
	localparam logic [5:0] C_NU = 6'd33;
	localparam logic [5:0] C_OP = 6'd34;
	localparam logic [5:0] C_PO = 6'd35;
	localparam logic [5:0] C_PR = 6'd36;
	localparam logic [5:0] C_QU = 6'd37;
	localparam logic [5:0] C_RI = 6'd38;
	localparam logic [5:0] C_SA = 6'd39;
	localparam logic [5:0] C_SG = 6'd40;
	localparam logic [5:0] C_SP = 6'd41;
	localparam logic [5:0] C_SY = 6'd42;
	localparam logic [5:0] C_VF = 6'd43;
	localparam logic [5:0] C_VI = 6'd44;
	localparam logic [5:0] C_WJ = 6'd45;
	localparam logic [5:0] C_XX = 6'd46;
	localparam logic [5:0] C_ZW = 6'd47;
	localparam logic [5:0] C_ZWJ = 6'd48;
	localparam logic [5:0] C_NONE = 6'd63;

	localparam logic [1:0] ACT_PROHIB = 2'd0;
	localparam logic [1:0] ACT_BREAK = 2'd1;
	localparam logic [1:0] ACT_MAND = 2'd2;

	// Flag bits of one character.
	localparam int F_QI = 0;
	localparam int F_QF = 1;
	localparam int F_EA = 2;
	localparam int F_UP = 3;
	localparam int F_DC = 4;
	// Flag bits kept for the character before the left one.
	localparam int BL_EA = 0;
	localparam int BL_DC = 1;
	localparam int BL_NUM = 2;
	// Lookahead predicate bits.
	localparam int LA_A = 0;
	localparam int LA_B = 1;
	localparam int LA_C = 2;
	localparam int LA_D = 3;
	localparam int LA_E = 4;

	localparam logic [63:0] S_HARD = (64'd1 << C_BK) | (64'd1 << C_CR) |
		(64'd1 << C_LF) | (64'd1 << C_NL);
	localparam logic [63:0] S_JAMO = (64'd1 << C_JL) | (64'd1 << C_JV) |
		(64'd1 << C_JT) | (64'd1 << C_H2) | (64'd1 << C_H3);
	localparam logic [63:0] S_ALHL = (64'd1 << C_AL) | (64'd1 << C_HL);
	localparam logic [63:0] S_PRPO = (64'd1 << C_PR) | (64'd1 << C_PO);
	localparam logic [63:0] S_IDEM = (64'd1 << C_ID) | (64'd1 << C_EB) | (64'd1 << C_EM);
	localparam logic [63:0] S_CLOSE = (64'd1 << C_SP) | (64'd1 << C_GL) |
		(64'd1 << C_WJ) | (64'd1 << C_CL) | (64'd1 << C_QU) | (64'd1 << C_CP) |
		(64'd1 << C_EX) | (64'd1 << C_IS) | (64'd1 << C_SY) | S_HARD | (64'd1 << C_ZW);
	localparam logic [63:0] S_NOBASE = S_HARD | (64'd1 << C_SP) | (64'd1 << C_ZW);

	typedef struct packed {
		logic [5:0] left_class;
		logic [4:0] left_flags;
		logic left_numeric_run;
		logic left_odd_ri;
		logic [5:0] before_left_class;
		logic [2:0] before_left_flags;
		logic [5:0] nonspace_class;
		logic nonspace_quote_initial;
		logic [5:0] nonspace_before_class;
		logic prev_raw_zwj;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		left_class: C_NONE, left_flags: 5'd0, left_numeric_run: 1'b0,
		left_odd_ri: 1'b0, before_left_class: C_NONE, before_left_flags: 3'd0,
		nonspace_class: C_NONE, nonspace_quote_initial: 1'b0,
		nonspace_before_class: C_NONE, prev_raw_zwj: 1'b0};

	typedef struct packed {
		logic valid;
		logic stage;
		logic [POS_BITS-1:0] pos;
		logic [31:0] mask;
		logic [4:0] known;
	} slot_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] pos;
		logic [1:0] act;
		logic fin;
	} res_t;

	typedef struct packed {
		logic [2:0] cnt;
		res_t [MAX_RES-1:0] r;
	} bundle_t;

	function automatic logic in_set(input logic [5:0] c, input logic [63:0] s);
		return s[c];
	endfunction

	function automatic logic [5:0] map_class(input logic [5:0] r);
		if (r > C_ZWJ || r == C_AI || r == C_SG || r == C_XX || r == C_SA)
			return C_AL;
		if (r == C_CJ)
			return C_NS;
		return r;
	endfunction

	function automatic logic ak_like(input logic [5:0] c, input logic dotted);
		return (c == C_AK) || (c == C_AS) || dotted;
	endfunction

	function automatic logic [OUT_POS_W-1:0] out_pos(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[OUT_POS_W-1:0];
	endfunction

	function automatic bundle_t add_res(input bundle_t bi, input logic [POS_BITS-1:0] p,
			input logic [1:0] act, input logic fin);
		bundle_t bo;
		bo = bi;
		if (bi.cnt < 3'(MAX_RES)) begin
			bo.r[bi.cnt[1:0]] = '{pos: out_pos(p), act: act, fin: fin};
			bo.cnt = bi.cnt + 3'd1;
		end
		return bo;
	endfunction

	// Rules LB4 to LB31 for the boundary before class a with flags af.
	function automatic logic [1:0] decide(input ctx_t x, input logic [5:0] a,
			input logic [4:0] af, input logic [4:0] la);
		logic [5:0] b;
		logic [5:0] k;
		logic [5:0] bl;
		logic [4:0] lf;
		logic [2:0] blf;
		logic [5:0] j;
		b = x.left_class;
		k = x.nonspace_class;
		bl = x.before_left_class;
		lf = x.left_flags;
		blf = x.before_left_flags;
		j = x.nonspace_before_class;
		if (b == C_BK) return ACT_MAND;
		if (b == C_CR && a == C_LF) return ACT_PROHIB;
		if (b == C_CR || b == C_LF || b == C_NL) return ACT_MAND;
		if (in_set(a, S_HARD)) return ACT_PROHIB;
		if (a == C_SP || a == C_ZW) return ACT_PROHIB;
		if (k == C_ZW) return ACT_BREAK;
		if (x.prev_raw_zwj) return ACT_PROHIB;
		if (a == C_WJ || b == C_WJ) return ACT_PROHIB;
		if (b == C_GL) return ACT_PROHIB;
		if (a == C_GL && !(b == C_SP || b == C_BA || b == C_HY || b == C_HH))
			return ACT_PROHIB;
		if (a == C_CL || a == C_CP || a == C_EX || a == C_SY) return ACT_PROHIB;
		if (k == C_OP) return ACT_PROHIB;
		if (k != C_NONE && x.nonspace_quote_initial) begin
			if (j == C_NONE || in_set(j, S_HARD | (64'd1 << C_OP) | (64'd1 << C_QU) |
					(64'd1 << C_GL) | (64'd1 << C_SP) | (64'd1 << C_ZW)))
				return ACT_PROHIB;
		end
		if (af[F_QF] && la[LA_A]) return ACT_PROHIB;
		if (b == C_SP && a == C_IS && la[LA_B]) return ACT_BREAK;
		if (a == C_IS) return ACT_PROHIB;
		if (a == C_NS && (k == C_CL || k == C_CP)) return ACT_PROHIB;
		if (a == C_B2 && k == C_B2) return ACT_PROHIB;
		if (b == C_SP) return ACT_BREAK;
		if (a == C_QU && !af[F_QI]) return ACT_PROHIB;
		if (b == C_QU && !lf[F_QF]) return ACT_PROHIB;
		if (a == C_QU) begin
			if (!lf[F_EA]) return ACT_PROHIB;
			if (la[LA_C]) return ACT_PROHIB;
		end
		if (b == C_QU) begin
			if (!af[F_EA]) return ACT_PROHIB;
			if (bl == C_NONE || !blf[BL_EA]) return ACT_PROHIB;
		end
		if (a == C_CB || b == C_CB) return ACT_BREAK;
		if (in_set(a, S_ALHL) && (b == C_HY || b == C_HH)) begin
			if (bl == C_NONE || in_set(bl, S_HARD | (64'd1 << C_SP) | (64'd1 << C_ZW) |
					(64'd1 << C_CB) | (64'd1 << C_GL)))
				return ACT_PROHIB;
		end
		if (a == C_BA || a == C_HH || a == C_HY || a == C_NS || b == C_BB)
			return ACT_PROHIB;
		if ((b == C_HY || b == C_HH) && a != C_HL && bl == C_HL) return ACT_PROHIB;
		if (b == C_SY && a == C_HL) return ACT_PROHIB;
		if (a == C_IN) return ACT_PROHIB;
		if (in_set(b, S_ALHL) && a == C_NU) return ACT_PROHIB;
		if (b == C_NU && in_set(a, S_ALHL)) return ACT_PROHIB;
		if (b == C_PR && in_set(a, S_IDEM)) return ACT_PROHIB;
		if (in_set(b, S_IDEM) && a == C_PO) return ACT_PROHIB;
		if (in_set(b, S_PRPO) && in_set(a, S_ALHL)) return ACT_PROHIB;
		if (in_set(b, S_ALHL) && in_set(a, S_PRPO)) return ACT_PROHIB;
		if ((b == C_CL || b == C_CP) && in_set(a, S_PRPO) && blf[BL_NUM]) return ACT_PROHIB;
		if (in_set(a, S_PRPO) && x.left_numeric_run) return ACT_PROHIB;
		if (in_set(b, S_PRPO)) begin
			if (a == C_NU) return ACT_PROHIB;
			if (a == C_OP && la[LA_D]) return ACT_PROHIB;
		end
		if (a == C_NU && (b == C_HY || b == C_IS || x.left_numeric_run)) return ACT_PROHIB;
		if (b == C_JL && (a == C_JL || a == C_JV || a == C_H2 || a == C_H3))
			return ACT_PROHIB;
		if ((b == C_JV || b == C_H2) && (a == C_JV || a == C_JT)) return ACT_PROHIB;
		if ((b == C_JT || b == C_H3) && a == C_JT) return ACT_PROHIB;
		if (in_set(b, S_JAMO) && a == C_PO) return ACT_PROHIB;
		if (b == C_PR && in_set(a, S_JAMO)) return ACT_PROHIB;
		if (in_set(b, S_ALHL) && in_set(a, S_ALHL)) return ACT_PROHIB;
		if (b == C_AP && ak_like(a, af[F_DC])) return ACT_PROHIB;
		if (ak_like(b, lf[F_DC]) && (a == C_VF || a == C_VI)) return ACT_PROHIB;
		if (b == C_VI && bl != C_NONE && ak_like(bl, blf[BL_DC]) &&
				(a == C_AK || af[F_DC]))
			return ACT_PROHIB;
		if (ak_like(b, lf[F_DC]) && ak_like(a, af[F_DC]) && la[LA_E]) return ACT_PROHIB;
		if (b == C_IS && in_set(a, S_ALHL)) return ACT_PROHIB;
		if (in_set(b, S_ALHL | (64'd1 << C_NU)) && a == C_OP && !af[F_EA])
			return ACT_PROHIB;
		if (b == C_CP && !lf[F_EA] && in_set(a, S_ALHL | (64'd1 << C_NU)))
			return ACT_PROHIB;
		if (b == C_RI && a == C_RI && x.left_odd_ri) return ACT_PROHIB;
		if (a == C_EM && (b == C_EB || lf[F_UP])) return ACT_PROHIB;
		return ACT_BREAK;
	endfunction

	// Offers the next character, or end of text, to one pending slot.
	function automatic slot_t feed_slot(input slot_t p, input logic [5:0] c,
			input logic ea, input logic eot, output logic em, output logic act);
		slot_t q;
		logic [4:0] kb;
		q = p;
		em = 1'b0;
		act = 1'b0;
		kb = 5'd0;
		if (p.valid) begin
			if (!p.stage) begin
				if (eot) begin
					kb[LA_A] = 1'b1;
					kb[LA_C] = 1'b1;
				end else begin
					kb[LA_A] = in_set(c, S_CLOSE);
					kb[LA_B] = (c == C_NU);
					kb[LA_D] = (c == C_NU);
					kb[LA_C] = !ea;
					kb[LA_E] = (c == C_VF);
				end
				// An IS may still be followed by NU; wait one more character.
				if (!eot && c == C_IS && p.mask[kb] != p.mask[kb | 5'b01000]) begin
					q.stage = 1'b1;
					q.known = kb;
				end else begin
					em = 1'b1;
					act = p.mask[kb];
					q.valid = 1'b0;
				end
			end else begin
				kb = p.known;
				if (!eot && c == C_NU)
					kb[LA_D] = 1'b1;
				em = 1'b1;
				act = p.mask[kb];
				q.valid = 1'b0;
			end
		end
		return q;
	endfunction

endpackage

`default_nettype wire

// File: design/ulb_front.sv
// ----------------------------------------------------------------------------
// ulb_front
// Accepts characters, applies the rule chain against the running context and
// packs the boundary results caused by one character into a bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module ulb_front
	import ulb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [5:0] line_class,
	input  wire logic       quote_initial,
	input  wire logic       quote_final,
	input  wire logic       east_asian,
	input  wire logic       unassigned_pictograph,
	input  wire logic       dotted_circle,
	input  wire logic       end_of_text,
	output logic            push_valid,
	input  wire logic       push_ready,
	output bundle_t         push_data
);

	logic [POS_BITS-1:0] count_q, count_d;
	ctx_t ctx_q, ctx_d;
	slot_t [1:0] pend_q, pend_d;

	logic [5:0] raw, c;
	logic [4:0] af;
	logic mark, absorb, accept;
	logic [31:0] mask;
	logic [1:0] first;
	logic [1:0] v;
	logic uniform;
	logic em, act;
	slot_t prev;
	bundle_t bnd;
	logic slot_sel;

	assign accept = in_valid && in_ready;
	assign in_ready = push_ready;

	always_comb begin
		raw = map_class(line_class);
		af = {dotted_circle, unassigned_pictograph, east_asian, quote_final, quote_initial};
		mark = (raw == C_CM) || (raw == C_ZWJ);
		absorb = mark && ctx_q.left_class != C_NONE && !in_set(ctx_q.left_class, S_NOBASE);
		c = mark ? C_AL : raw;

		first = decide(ctx_q, c, af, 5'd0);
		mask = '0;
		uniform = 1'b1;
		for (int i = 0; i < 32; i++) begin
			v = decide(ctx_q, c, af, 5'(i));
			mask[i] = (v == ACT_BREAK);
			if (v != first)
				uniform = 1'b0;
		end

		bnd = '0;
		pend_d = pend_q;
		ctx_d = ctx_q;
		em = 1'b0;
		act = 1'b0;
		prev = '0;
		slot_sel = 1'b0;

		if (absorb) begin
			bnd = add_res(bnd, count_q, ACT_PROHIB, 1'b0);
		end else begin
			for (int s = 0; s < 2; s++) begin
				prev = pend_d[s];
				pend_d[s] = feed_slot(prev, c, af[F_EA], 1'b0, em, act);
				if (em)
					bnd = add_res(bnd, prev.pos, {1'b0, act}, 1'b0);
			end
			if (!pend_d[0].valid && pend_d[1].valid) begin
				pend_d[0] = pend_d[1];
				pend_d[1].valid = 1'b0;
			end
			if (ctx_q.left_class == C_NONE) begin
				bnd = add_res(bnd, count_q, ACT_PROHIB, 1'b0);
			end else if (uniform) begin
				bnd = add_res(bnd, count_q, first, 1'b0);
			end else begin
				slot_sel = pend_d[0].valid;
				if (pend_d[slot_sel].valid)
					bnd = add_res(bnd, pend_d[slot_sel].pos,
						{1'b0, pend_d[slot_sel].mask[5'b00101]}, 1'b0);
				pend_d[slot_sel] = '{valid: 1'b1, stage: 1'b0, pos: count_q,
					mask: mask, known: 5'd0};
			end

			if (c == C_NU)
				ctx_d.left_numeric_run = 1'b1;
			else if (c == C_SY || c == C_IS)
				ctx_d.left_numeric_run = ctx_q.left_numeric_run;
			else
				ctx_d.left_numeric_run = 1'b0;
			if (c != C_RI)
				ctx_d.left_odd_ri = 1'b0;
			else if (ctx_q.left_class == C_RI)
				ctx_d.left_odd_ri = !ctx_q.left_odd_ri;
			else
				ctx_d.left_odd_ri = 1'b1;
			if (c != C_SP) begin
				ctx_d.nonspace_class = c;
				ctx_d.nonspace_quote_initial = af[F_QI];
				ctx_d.nonspace_before_class = ctx_q.left_class;
			end
			ctx_d.before_left_class = ctx_q.left_class;
			ctx_d.before_left_flags = {ctx_q.left_numeric_run, ctx_q.left_flags[F_DC],
				ctx_q.left_flags[F_EA]};
			ctx_d.left_class = c;
			ctx_d.left_flags = af;
		end
		ctx_d.prev_raw_zwj = (raw == C_ZWJ);
		count_d = count_q + POS_BITS'(1);

		if (end_of_text) begin
			for (int s = 0; s < 2; s++) begin
				prev = pend_d[s];
				pend_d[s] = feed_slot(prev, 6'd0, 1'b0, 1'b1, em, act);
				if (em)
					bnd = add_res(bnd, prev.pos, {1'b0, act}, 1'b0);
			end
			bnd = add_res(bnd, count_d, ACT_MAND, 1'b1);
			// The next transfer starts a new text.
			pend_d = '0;
			ctx_d = CTX_RESET;
			count_d = '0;
		end

		push_data = bnd;
		push_valid = accept && (bnd.cnt != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctx_q <= CTX_RESET;
			pend_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
			ctx_q <= ctx_d;
			pend_q <= pend_d;
		end
	end

endmodule

`default_nettype wire

// File: design/ulb_queue.sv
// ----------------------------------------------------------------------------
// ulb_queue
// Two-entry queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ulb_queue
	import ulb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_valid,
	output logic         wr_ready,
	input  wire bundle_t wr_data,
	output logic         rd_valid,
	input  wire logic    rd_ready,
	output bundle_t      rd_data
);

	bundle_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic do_wr, do_rd;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data = entry_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd)
				fill_q <= fill_q + 2'd1;
			else if (do_rd && !do_wr)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// File: design/ulb_back.sv
// ----------------------------------------------------------------------------
// ulb_back
// Takes bundles from the queue and hands out their results one per transfer
// from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulb_back
	import ulb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pop_valid,
	output logic         pop_ready,
	input  wire bundle_t pop_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output logic [15:0]  boundary_pos,
	output logic [1:0]   action,
	output logic         final_result
);

	bundle_t cur_q;
	logic [1:0] idx_q;
	logic busy_q;
	logic last;
	res_t r;

	assign r = cur_q.r[idx_q];
	assign out_valid = busy_q;
	assign boundary_pos = r.pos;
	assign action = r.act;
	assign final_result = r.fin;
	assign last = ({1'b0, idx_q} + 3'd1 == cur_q.cnt);
	// The next bundle loads as the last result of the current one leaves.
	assign pop_ready = !busy_q || (out_ready && last);

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready)
			cur_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (pop_valid && pop_ready) begin
			busy_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (busy_q && out_ready) begin
			if (last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// File: design/unicode_line_break_rules_top.sv
// ----------------------------------------------------------------------------
// unicode_line_break_rules_top
// Line breaking over a stream of classified characters (rules LB2 to LB31).
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_ready    line_class and five property flags,
//                                             end_of_text
//  out      source     out_valid / out_ready  boundary_pos, action, final_result
//
// A character is taken every cycle while the two-bundle queue has room; its
// rule chain and lookahead bookkeeping settle in that same cycle.
// Each character yields up to four results, sent one per cycle while out_ready
// is high, from the output register, so the result port sets the sustained rate.
// Reset puts the context at start of text, the queue empty and out_valid low.
// A stalled result port fills the queue and then holds in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_line_break_rules_top
	import ulb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [5:0] line_class,
	input  wire logic       quote_initial,
	input  wire logic       quote_final,
	input  wire logic       east_asian,
	input  wire logic       unassigned_pictograph,
	input  wire logic       dotted_circle,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [15:0]     boundary_pos,
	output logic [1:0]      action,
	output logic            final_result
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	bundle_t push_data, pop_data;

	ulb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.line_class(line_class), .quote_initial(quote_initial),
		.quote_final(quote_final), .east_asian(east_asian),
		.unassigned_pictograph(unassigned_pictograph),
		.dotted_circle(dotted_circle), .end_of_text(end_of_text),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	ulb_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
		.rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data)
	);

	ulb_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.boundary_pos(boundary_pos), .action(action), .final_result(final_result)
	);

endmodule

`default_nettype wire

// File: design/ulb_checker.sv
// ----------------------------------------------------------------------------
// ulb_checker
// Port-level checks on the result channel of the line break block.
// ----------------------------------------------------------------------------
`default_nettype none

module ulb_checker
	import ulb_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] boundary_pos,
	input wire logic [1:0]  action,
	input wire logic        final_result
);

	// The end-of-text result is always the mandatory break.
	a_final_mand: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_result |-> action == ACT_MAND)
		else $error("final result without mandatory break");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action == ACT_PROHIB || action == ACT_BREAK || action == ACT_MAND)
		else $error("undefined action code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(boundary_pos) &&
			$stable(action) && $stable(final_result))
		else $error("stalled result changed");

	// No result appears before any character has been taken; checked as out_valid low after reset.
	a_no_early: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result without input");

endmodule

bind unicode_line_break_rules_top ulb_checker u_ulb_checker (.*);

`default_nettype wire
